// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rgb convolution rtl
// no dependencies; included by modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define CHK_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("check failed");
`else
`define CHK_ASSERT(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/rgbc3_pkg.sv =====
// shared types, constants and weight lookup for the rgb 3x3 convolution
// no dependencies
package rgbc3_pkg;

    localparam int CH_W             = 8;
    localparam int PIX_W            = 24;
    localparam int SUM_W            = 20;
    localparam int CNT_W            = 11;
    localparam int REM_W            = 19;
    localparam int TAP_W            = 4;
    localparam int TAP_LAST         = 8;
    localparam int DIV_LAST         = 7;
    localparam int SIZE_W           = 11;
    localparam int MAX_FRAME_HEIGHT = 1024;

    localparam logic [1:0] REG_WEIGHTS_UPPER = 2'd0;
    localparam logic [1:0] REG_WEIGHTS_LOWER = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd3;

    typedef struct packed {
        logic             accept;
        logic             shift;
        logic             mac_en;
        logic [TAP_W-1:0] tap;
        logic             div_init;
        logic             div_en;
        logic [2:0]       div_bit;
        logic             out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic out_busy;
    } ctrl_stat_t;

    function automatic logic signed [7:0] tap_weight(input logic [47:0] wu,
                                                     input logic [23:0] wl,
                                                     input logic [TAP_W-1:0] tap);
        logic signed [7:0] w;
        case (tap)
            4'd0: w = wu[7:0];
            4'd1: w = wu[15:8];
            4'd2: w = wu[23:16];
            4'd3: w = wu[31:24];
            4'd4: w = wu[39:32];
            4'd5: w = wu[47:40];
            4'd6: w = wl[7:0];
            4'd7: w = wl[15:8];
            4'd8: w = wl[23:16];
            default: w = 8'sd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rgbc3_ctrl.sv =====
// sequencer for the rgb 3x3 convolution: accept, window shift, mac, divide, output
// depends on rgbc3_pkg and assert_macros.svh
`include "assert_macros.svh"
module rgbc3_ctrl
    import rgbc3_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [TAP_W-1:0] step_reg, step_next;
    logic             accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.accept   = accept;
        cmd.tap      = step_reg;
        cmd.div_bit  = step_reg[2:0];
        case (state_reg)
            S_IDLE: begin
                if (accept && !stat.drop) state_next = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                step_next = '0;
                state_next = stat.emit ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                cmd.mac_en = 1'b1;
                if (step_reg == TAP_W'(TAP_LAST)) begin
                    state_next = S_PREP;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PREP: begin
                cmd.div_init = 1'b1;
                step_next = TAP_W'(DIV_LAST);
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_en = 1'b1;
                if (step_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `CHK_ASSERT(a_start, aclk, aresetn, (accept && !stat.drop) |=> (state_reg == S_SHIFT))
    `CHK_ASSERT(a_tap_range, aclk, aresetn, (state_reg == S_MAC) |-> (step_reg <= TAP_W'(TAP_LAST)))
    `CHK_ASSERT(a_div_range, aclk, aresetn, (state_reg == S_DIV) |-> (step_reg <= TAP_W'(DIV_LAST)))
    `CHK_ASSERT(a_out_done, aclk, aresetn, (state_reg == S_OUT && !stat.out_busy) |=> (state_reg == S_IDLE))

endmodule

// ===== rtl/rgbc3_datapath.sv =====
// line stores, window, position counters, multiply-accumulate and divider
// depends on rgbc3_pkg
module rgbc3_datapath
    import rgbc3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctrl_cmd_t         cmd,
    output ctrl_stat_t        stat,
    input  logic              op,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic [47:0]       weights_upper,
    input  logic [23:0]       weights_lower,
    input  logic [SIZE_W-1:0] frame_width,
    input  logic [SIZE_W-1:0] frame_height,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              end_of_frame,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int LW = (WW > SIZE_W) ? WW : SIZE_W;

    logic [PIX_W-1:0] prev_mem [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] old_mem  [MAX_LINE_WIDTH];
    logic [PIX_W-1:0] win_reg  [9];

    logic [CW-1:0]     col_reg;
    logic [SIZE_W-1:0] row_reg;
    logic [CW-1:0]     addr_reg;
    logic [PIX_W-1:0]  px_reg, prev_rd_reg, old_rd_reg;
    logic              emit_reg, eof_reg;
    logic              left_reg, right_reg, up_reg, down_reg;

    logic signed [SUM_W-1:0] sum_reg [3];
    logic [CNT_W-1:0]        cnt_reg;
    logic [REM_W-1:0]        rem_reg [3];
    logic [CH_W-1:0]         q_reg   [3];

    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg, out_valid_reg;

    logic [WW-1:0]     wc, cnext;
    logic [SIZE_W-1:0] hc;
    logic [LW-1:0]     fw_ext;
    logic              restart, drain, last_a, emit_a, emit_b;
    logic [CW-1:0]     c;
    logic [SIZE_W-1:0] r;
    logic [SIZE_W:0]   hp1;

    always_comb begin
        fw_ext = LW'(frame_width);
        if (frame_width == '0) wc = WW'(1);
        else if (fw_ext > LW'(MAX_LINE_WIDTH)) wc = WW'(MAX_LINE_WIDTH);
        else wc = WW'(fw_ext);
        if (frame_height == '0) hc = SIZE_W'(1);
        else if (frame_height > SIZE_W'(MAX_FRAME_HEIGHT)) hc = SIZE_W'(MAX_FRAME_HEIGHT);
        else hc = frame_height;
        hp1     = {1'b0, hc} + 1'b1;
        restart = (WW'(col_reg) >= wc) || ({1'b0, row_reg} > hp1);
        c       = restart ? '0 : col_reg;
        r       = restart ? '0 : row_reg;
        drain   = (r >= hc);
        last_a  = (c == '0) && ({1'b0, r} == hp1);
        emit_a  = (c == '0) && (r >= SIZE_W'(2));
        emit_b  = (c != '0) && (r >= SIZE_W'(1));
        cnext   = WW'(c) + 1'b1;
    end

    assign stat.drop     = !drain && op;
    assign stat.emit     = emit_reg;
    assign stat.out_busy = out_valid_reg && !out_ready;

    // position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.accept) begin
            if (stat.drop) begin
                col_reg <= c;
                row_reg <= r;
            end else if (last_a) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (cnext >= wc) begin
                col_reg <= '0;
                row_reg <= r + 1'b1;
            end else begin
                col_reg <= cnext[CW-1:0];
                row_reg <= r;
            end
        end
    end

    // item latch and line store read
    always_ff @(posedge aclk) begin
        if (cmd.accept && !stat.drop) begin
            addr_reg    <= c;
            px_reg      <= drain ? '0 : pixel_in;
            prev_rd_reg <= prev_mem[c];
            old_rd_reg  <= old_mem[c];
            emit_reg    <= emit_a || emit_b;
            if (c == '0) begin
                eof_reg   <= last_a;
                left_reg  <= (wc >= WW'(2));
                right_reg <= 1'b0;
                up_reg    <= (r >= SIZE_W'(3));
                down_reg  <= ({1'b0, r} < hp1);
            end else begin
                eof_reg   <= 1'b0;
                left_reg  <= (c >= CW'(2));
                right_reg <= 1'b1;
                up_reg    <= (r >= SIZE_W'(2));
                down_reg  <= (r < hc);
            end
        end
    end

    // window shift and line store write
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2]         <= old_rd_reg;
            win_reg[5]         <= prev_rd_reg;
            win_reg[8]         <= px_reg;
            old_mem[addr_reg]  <= prev_rd_reg;
            prev_mem[addr_reg] <= px_reg;
        end
    end

    logic signed [7:0]  wt;
    logic [7:0]         wt_abs;
    logic               row_top, row_bot, col_l, col_r, tap_used;
    logic [PIX_W-1:0]   tap_px;
    logic signed [16:0] prod [3];

    always_comb begin
        wt      = tap_weight(weights_upper, weights_lower, cmd.tap);
        wt_abs  = wt[7] ? 8'(-wt) : 8'(wt);
        row_top = (cmd.tap < TAP_W'(3));
        row_bot = (cmd.tap >= TAP_W'(6));
        col_l   = (cmd.tap == TAP_W'(0)) || (cmd.tap == TAP_W'(3)) || (cmd.tap == TAP_W'(6));
        col_r   = (cmd.tap == TAP_W'(2)) || (cmd.tap == TAP_W'(5)) || (cmd.tap == TAP_W'(8));
        tap_used = (wt != 8'sd0) && (!row_top || up_reg) && (!row_bot || down_reg)
                && (!col_l || left_reg) && (!col_r || right_reg);
        tap_px  = win_reg[cmd.tap];
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = wt * $signed({1'b0, tap_px[CH_W*(2-ch) +: CH_W]});
        end
    end

    // accumulate, then restoring division one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            for (int ch = 0; ch < 3; ch++) sum_reg[ch] <= '0;
            cnt_reg <= '0;
        end else if (cmd.mac_en && tap_used) begin
            for (int ch = 0; ch < 3; ch++) sum_reg[ch] <= sum_reg[ch] + SUM_W'(prod[ch]);
            cnt_reg <= cnt_reg + CNT_W'(wt_abs);
        end
        if (cmd.div_init) begin
            for (int ch = 0; ch < 3; ch++) begin
                rem_reg[ch] <= (sum_reg[ch] > 0) ? REM_W'(sum_reg[ch]) : '0;
                q_reg[ch]   <= '0;
            end
        end else if (cmd.div_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (rem_reg[ch] >= (REM_W'(cnt_reg) << cmd.div_bit)) begin
                    rem_reg[ch] <= rem_reg[ch] - (REM_W'(cnt_reg) << cmd.div_bit);
                    q_reg[ch][cmd.div_bit] <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= (cnt_reg == '0) ? '0 : {q_reg[0], q_reg[1], q_reg[2]};
            out_last_reg <= eof_reg;
        end
    end

    assign pixel_out    = out_data_reg;
    assign end_of_frame = out_last_reg;
    assign out_valid    = out_valid_reg;

endmodule

// ===== rtl/rgb_convolution_3x3_normalized.sv =====
// Normalized 3x3 convolution of a raster-order 24-bit rgb stream. For an item with
// a pixel that produces a result, the line stores are read at the transfer, the
// window shifts, the nine taps pass one at a time through the single per-channel
// multiply-accumulate, a setup step prepares the bit-serial divider, the divider
// runs and the result is loaded into the output register, which waits as long as
// a previous result is stalled; no new transfer is taken until it is loaded. Items
// without a result return to idle after the window shift; ignored flush items keep
// the sequencer idle. Results lag the input by one line and one pixel, so send
// frame_width+1 flush items (tuser = 1) after the last pixel.
// depends on rgbc3_pkg, rgbc3_ctrl, rgbc3_datapath
module rgb_convolution_3x3_normalized
    import rgbc3_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_in
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_out
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [47:0]       weights_upper_reg;
    logic [23:0]       weights_lower_reg;
    logic [SIZE_W-1:0] frame_width_reg, frame_height_reg;
    ctrl_cmd_t         cmd;
    ctrl_stat_t        stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weights_upper_reg <= 48'd3332945019649;
            weights_lower_reg <= 24'd66305;
            frame_width_reg   <= SIZE_W'(640);
            frame_height_reg  <= SIZE_W'(480);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WEIGHTS_UPPER: weights_upper_reg <= cfg_data;
                REG_WEIGHTS_LOWER: weights_lower_reg <= cfg_data[23:0];
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    rgbc3_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rgbc3_datapath #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .op            (s_tuser[0]),
        .pixel_in      (s_tdata),
        .weights_upper (weights_upper_reg),
        .weights_lower (weights_lower_reg),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .pixel_out     (m_tdata),
        .end_of_frame  (m_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready)
    );

endmodule
